// ----- src/bcl_pkg.sv -----
// ----------------------------------------------------------------------------
// bcl_pkg
// Shared codes, widths and constants of the bytecode chunk line table.
// ----------------------------------------------------------------------------
package bcl_pkg;

  // Field widths
  localparam int ACTION_W   = 2;
  localparam int BYTE_W     = 8;
  localparam int LINE_W     = 16;
  localparam int VALUE_W    = 64;
  localparam int OFFSET_W   = 12;
  localparam int STATUS_W   = 2;
  localparam int CINDEX_W   = 10;
  localparam int LENGTH_W   = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  typedef logic [ACTION_W-1:0]   action_t;
  typedef logic [BYTE_W-1:0]     byte_t;
  typedef logic [LINE_W-1:0]     line_t;
  typedef logic [VALUE_W-1:0]    value_t;
  typedef logic [OFFSET_W-1:0]   offset_t;
  typedef logic [STATUS_W-1:0]   status_t;
  typedef logic [CINDEX_W-1:0]   cindex_t;
  typedef logic [LENGTH_W-1:0]   length_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  // Actions
  localparam action_t ACT_WRITE_BYTE  = 2'd0;
  localparam action_t ACT_WRITE_CONST = 2'd1;
  localparam action_t ACT_LOOKUP      = 2'd2;
  localparam action_t ACT_CLEAR       = 2'd3;

  // Result status
  localparam status_t STAT_OK         = 2'd0;
  localparam status_t STAT_CODE_FULL  = 2'd1;
  localparam status_t STAT_LINE_FULL  = 2'd2;
  localparam status_t STAT_POOL_FULL  = 2'd3;

  // Configuration register indexes
  localparam cfg_idx_t REG_SHORT_OP   = 1'b0;
  localparam cfg_idx_t REG_LONG_OP    = 1'b1;

  localparam byte_t SHORT_OP_RESET    = 8'd0;
  localparam byte_t LONG_OP_RESET     = 8'd1;

  // Pool index limits
  localparam logic [31:0] SHORT_INDEX_MAX = 32'd255;
  localparam logic [31:0] LONG_INDEX_MAX  = 32'hffffff;

  // Byte counts of the emitted instructions
  localparam logic [2:0] BYTES_WRITE = 3'd1;
  localparam logic [2:0] BYTES_SHORT = 3'd2;
  localparam logic [2:0] BYTES_LONG  = 3'd4;

endpackage

// ----- src/bcl_if.sv -----
// ----------------------------------------------------------------------------
// bcl_if
// Valid/ready channels carrying request items and result items.
// ----------------------------------------------------------------------------
interface bcl_in_if;
  import bcl_pkg::*;

  logic    valid;
  logic    ready;
  action_t action;
  byte_t   data_byte;
  line_t   source_line;
  value_t  constant_value;
  offset_t code_offset;

  modport source (output valid, action, data_byte, source_line, constant_value,
                  code_offset, input ready);
  modport sink   (input valid, action, data_byte, source_line, constant_value,
                  code_offset, output ready);
endinterface

interface bcl_out_if;
  import bcl_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  line_t   found_line;
  logic    line_found;
  cindex_t constant_index;
  length_t code_length;

  modport source (output valid, status, found_line, line_found, constant_index,
                  code_length, input ready);
  modport sink   (input valid, status, found_line, line_found, constant_index,
                  code_length, output ready);
endinterface

// ----- src/bytecode_chunk_line_table_top.sv -----
// Emitting moves one code byte per cycle through the single code store port;
//   clear, refused writes and lookups on an empty table answer from idle;
//   a lookup reads (S_RD) and then checks (S_CK) each run in turn.
// One item is handled at a time; the next is taken once the result is out
//   or leaving. Reset (rst_n, synchronous, active low) empties all stores by
//   clearing the counts and sets the opcodes to 0 and 1; no clearing pass.
// ----------------------------------------------------------------------------
// bytecode_chunk_line_table_top
// Bytecode chunk with run-length line table and constant pool. A small
// sequencer drives one shared adder for run extension and the lookup walk.
// ----------------------------------------------------------------------------
module bytecode_chunk_line_table_top #(
  parameter int CODE_DEPTH  = 4096,
  parameter int RUN_DEPTH   = 1024,
  parameter int CONST_DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  bcl_in_if.sink              in_if,
  bcl_out_if.source           out_if,
  input  logic                cfg_we,
  input  bcl_pkg::cfg_idx_t   cfg_index,
  input  bcl_pkg::cfg_data_t  cfg_wdata
);
  import bcl_pkg::*;

  // Derived widths
  localparam int CW      = $clog2(CODE_DEPTH + 1);
  localparam int CAW     = $clog2(CODE_DEPTH);
  localparam int RW      = $clog2(RUN_DEPTH + 1);
  localparam int RAW     = $clog2(RUN_DEPTH);
  localparam int KW      = $clog2(CONST_DEPTH + 1);
  localparam int KAW     = $clog2(CONST_DEPTH);
  localparam int SW      = (CW > OFFSET_W) ? CW : OFFSET_W;
  localparam int ENTRY_W = LINE_W + CW;

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EMIT = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;
  localparam logic [1:0] S_CK   = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] code_cnt_r, code_cnt_nxt;
  logic [RW-1:0] run_cnt_r, run_cnt_nxt;
  logic [KW-1:0] const_cnt_r, const_cnt_nxt;
  byte_t         short_op_r, long_op_r;

  line_t         last_line_r, last_line_nxt;
  logic [CW-1:0] last_len_r, last_len_nxt;

  // Latched item and emit queue
  line_t         line_r, line_nxt;
  offset_t       offset_r, offset_nxt;
  byte_t         emit_q_r [4];
  byte_t         emit_q_nxt [4];
  logic [2:0]    emit_left_r, emit_left_nxt;
  cindex_t       cindex_r, cindex_nxt;

  // Lookup walk
  logic [RW-1:0] walk_idx_r, walk_idx_nxt;
  logic [CW-1:0] start_r, start_nxt;

  // Result register
  logic          out_valid_r, out_valid_nxt;
  status_t       res_status_r, res_status_nxt;
  line_t         res_line_r, res_line_nxt;
  logic          res_found_r, res_found_nxt;
  cindex_t       res_cindex_r, res_cindex_nxt;
  length_t       res_length_r, res_length_nxt;

  // Memory ports
  logic                  code_we;
  logic [CAW-1:0]        code_addr;
  logic                  pool_we;
  logic                  run_we;
  logic [RAW-1:0]        run_waddr;
  logic [ENTRY_W-1:0]    run_wdata;
  logic                  run_re;
  logic [ENTRY_W-1:0]    run_rdata;

  // Accept-time checks
  logic          accept;
  logic          is_short;
  logic [2:0]    n_bytes;
  logic          new_run_in;
  logic          code_fail, line_fail, pool_fail;
  status_t       chk_status;
  logic [23:0]   idx24;

  // Shared adder
  logic [CW-1:0] add_a, add_b, add_sum;
  logic          new_run_emit;
  logic          hit;

  bcl_code_mem #(
    .CODE_DEPTH  (CODE_DEPTH),
    .CONST_DEPTH (CONST_DEPTH)
  ) u_code_mem (
    .clk        (clk),
    .code_we    (code_we),
    .code_addr  (code_addr),
    .code_wdata (emit_q_r[0]),
    .pool_we    (pool_we),
    .pool_addr  (const_cnt_r[KAW-1:0]),
    .pool_wdata (in_if.constant_value)
  );

  bcl_run_mem #(
    .RUN_DEPTH (RUN_DEPTH),
    .ENTRY_W   (ENTRY_W)
  ) u_run_mem (
    .clk   (clk),
    .we    (run_we),
    .waddr (run_waddr),
    .wdata (run_wdata),
    .re    (run_re),
    .raddr (walk_idx_r[RAW-1:0]),
    .rdata (run_rdata)
  );

  // Handshake
  assign in_if.ready = (state_r == S_IDLE) && (!out_valid_r || out_if.ready);
  assign accept      = in_if.valid && in_if.ready;

  // Room checks for the offered item
  always_comb begin
    is_short   = 32'(const_cnt_r) <= SHORT_INDEX_MAX;
    idx24      = 24'(const_cnt_r);
    n_bytes    = (in_if.action == ACT_WRITE_BYTE) ? BYTES_WRITE :
                 (is_short ? BYTES_SHORT : BYTES_LONG);
    new_run_in = (run_cnt_r == '0) || (last_line_r != in_if.source_line);
    pool_fail  = (const_cnt_r >= KW'(CONST_DEPTH)) ||
                 (32'(const_cnt_r) > LONG_INDEX_MAX);
    code_fail  = ((CW+1)'(code_cnt_r) + (CW+1)'(n_bytes)) > (CW+1)'(CODE_DEPTH);
    line_fail  = new_run_in && (run_cnt_r >= RW'(RUN_DEPTH));
    if (in_if.action == ACT_WRITE_CONST && pool_fail) begin
      chk_status = STAT_POOL_FULL;
    end else if (code_fail) begin
      chk_status = STAT_CODE_FULL;
    end else if (line_fail) begin
      chk_status = STAT_LINE_FULL;
    end else begin
      chk_status = STAT_OK;
    end
  end

  // Shared adder: run extension while emitting, start + length while walking
  assign new_run_emit = (run_cnt_r == '0) || (last_line_r != line_r);
  assign add_a   = (state_r == S_CK) ? start_r : last_len_r;
  assign add_b   = (state_r == S_CK) ? run_rdata[CW-1:0] : CW'(1);
  assign add_sum = add_a + add_b;
  assign hit     = SW'(offset_r) < SW'(add_sum);

  // Memory writes
  assign code_we   = (state_r == S_EMIT);
  assign code_addr = code_cnt_r[CAW-1:0];
  assign pool_we   = accept && (in_if.action == ACT_WRITE_CONST) && (chk_status == STAT_OK);
  assign run_we    = (state_r == S_EMIT);
  assign run_waddr = new_run_emit ? run_cnt_r[RAW-1:0] : RAW'(run_cnt_r - RW'(1));
  assign run_wdata = new_run_emit ? {line_r, CW'(1)} : {line_r, add_sum};
  assign run_re    = (state_r == S_RD);

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    code_cnt_nxt   = code_cnt_r;
    run_cnt_nxt    = run_cnt_r;
    const_cnt_nxt  = const_cnt_r;
    last_line_nxt  = last_line_r;
    last_len_nxt   = last_len_r;
    line_nxt       = line_r;
    offset_nxt     = offset_r;
    emit_q_nxt     = emit_q_r;
    emit_left_nxt  = emit_left_r;
    cindex_nxt     = cindex_r;
    walk_idx_nxt   = walk_idx_r;
    start_nxt      = start_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    res_status_nxt = res_status_r;
    res_line_nxt   = res_line_r;
    res_found_nxt  = res_found_r;
    res_cindex_nxt = res_cindex_r;
    res_length_nxt = res_length_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          line_nxt       = in_if.source_line;
          offset_nxt     = in_if.code_offset;
          res_status_nxt = STAT_OK;
          res_line_nxt   = '0;
          res_found_nxt  = 1'b0;
          res_cindex_nxt = '0;
          res_length_nxt = LENGTH_W'(code_cnt_r);
          cindex_nxt     = '0;
          case (in_if.action) inside
            ACT_WRITE_BYTE, ACT_WRITE_CONST: begin
              if (chk_status != STAT_OK) begin
                res_status_nxt = chk_status;
                out_valid_nxt  = 1'b1;
              end else begin
                emit_left_nxt = n_bytes;
                if (in_if.action == ACT_WRITE_BYTE) begin
                  emit_q_nxt[0] = in_if.data_byte;
                end else begin
                  const_cnt_nxt = const_cnt_r + KW'(1);
                  cindex_nxt    = CINDEX_W'(const_cnt_r);
                  if (is_short) begin
                    emit_q_nxt[0] = short_op_r;
                    emit_q_nxt[1] = idx24[7:0];
                  end else begin
                    emit_q_nxt[0] = long_op_r;
                    emit_q_nxt[1] = idx24[23:16];
                    emit_q_nxt[2] = idx24[15:8];
                    emit_q_nxt[3] = idx24[7:0];
                  end
                end
                state_nxt = S_EMIT;
              end
            end
            ACT_LOOKUP: begin
              walk_idx_nxt = '0;
              start_nxt    = '0;
              if (run_cnt_r == '0) begin
                out_valid_nxt = 1'b1;
              end else begin
                state_nxt = S_RD;
              end
            end
            default: begin
              code_cnt_nxt   = '0;
              run_cnt_nxt    = '0;
              const_cnt_nxt  = '0;
              res_length_nxt = '0;
              out_valid_nxt  = 1'b1;
            end
          endcase
        end
      end

      // One code byte per cycle, extending or opening a run
      S_EMIT: begin
        code_cnt_nxt = code_cnt_r + CW'(1);
        if (new_run_emit) begin
          run_cnt_nxt   = run_cnt_r + RW'(1);
          last_line_nxt = line_r;
          last_len_nxt  = CW'(1);
        end else begin
          last_len_nxt = add_sum;
        end
        emit_q_nxt[0] = emit_q_r[1];
        emit_q_nxt[1] = emit_q_r[2];
        emit_q_nxt[2] = emit_q_r[3];
        emit_left_nxt = emit_left_r - 3'd1;
        if (emit_left_r == 3'd1) begin
          res_cindex_nxt = cindex_r;
          res_length_nxt = LENGTH_W'(code_cnt_r + CW'(1));
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      S_RD: begin
        state_nxt = S_CK;
      end

      // Check one run against the offset
      S_CK: begin
        if (hit) begin
          res_line_nxt  = run_rdata[ENTRY_W-1:CW];
          res_found_nxt = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          start_nxt    = add_sum;
          walk_idx_nxt = walk_idx_r + RW'(1);
          if (walk_idx_r + RW'(1) == run_cnt_r) begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            state_nxt = S_RD;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      code_cnt_r  <= '0;
      run_cnt_r   <= '0;
      const_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      code_cnt_r  <= code_cnt_nxt;
      run_cnt_r   <= run_cnt_nxt;
      const_cnt_r <= const_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Opcode registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_op_r <= SHORT_OP_RESET;
      long_op_r  <= LONG_OP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SHORT_OP: short_op_r <= cfg_wdata;
        REG_LONG_OP:  long_op_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    last_line_r  <= last_line_nxt;
    last_len_r   <= last_len_nxt;
    line_r       <= line_nxt;
    offset_r     <= offset_nxt;
    emit_q_r     <= emit_q_nxt;
    emit_left_r  <= emit_left_nxt;
    cindex_r     <= cindex_nxt;
    walk_idx_r   <= walk_idx_nxt;
    start_r      <= start_nxt;
    res_status_r <= res_status_nxt;
    res_line_r   <= res_line_nxt;
    res_found_r  <= res_found_nxt;
    res_cindex_r <= res_cindex_nxt;
    res_length_r <= res_length_nxt;
  end

  // Result channel
  assign out_if.valid          = out_valid_r;
  assign out_if.status         = res_status_r;
  assign out_if.found_line     = res_line_r;
  assign out_if.line_found     = res_found_r;
  assign out_if.constant_index = res_cindex_r;
  assign out_if.code_length    = res_length_r;

endmodule

// ----- src/bcl_code_mem.sv -----
// ----------------------------------------------------------------------------
// bcl_code_mem
// Bytecode store and constant pool, each a single write-port memory.
// ----------------------------------------------------------------------------
module bcl_code_mem #(
  parameter int CODE_DEPTH  = 4096,
  parameter int CONST_DEPTH = 1024
) (
  input  logic                           clk,
  input  logic                           code_we,
  input  logic [$clog2(CODE_DEPTH)-1:0]  code_addr,
  input  bcl_pkg::byte_t                 code_wdata,
  input  logic                           pool_we,
  input  logic [$clog2(CONST_DEPTH)-1:0] pool_addr,
  input  bcl_pkg::value_t                pool_wdata
);
  import bcl_pkg::*;

  byte_t  code_mem [CODE_DEPTH];
  value_t pool_mem [CONST_DEPTH];

  // Code store write port
  always_ff @(posedge clk) begin
    if (code_we) begin
      code_mem[code_addr] <= code_wdata;
    end
  end

  // Constant pool write port
  always_ff @(posedge clk) begin
    if (pool_we) begin
      pool_mem[pool_addr] <= pool_wdata;
    end
  end

endmodule

// ----- src/bcl_run_mem.sv -----
// ----------------------------------------------------------------------------
// bcl_run_mem
// Line run table: one entry per run holding {line, length}; one write port
// and one registered read port.
// ----------------------------------------------------------------------------
module bcl_run_mem #(
  parameter int RUN_DEPTH = 1024,
  parameter int ENTRY_W   = 29
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [$clog2(RUN_DEPTH)-1:0] waddr,
  input  logic [ENTRY_W-1:0]           wdata,
  input  logic                         re,
  input  logic [$clog2(RUN_DEPTH)-1:0] raddr,
  output logic [ENTRY_W-1:0]           rdata
);

  logic [ENTRY_W-1:0] mem [RUN_DEPTH];
  logic [ENTRY_W-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
